// ----- design/ddoc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Date day-offset converter package
// Shared types, calendar constants and month-length helpers for the
// controller and datapath of the date day-offset converter.
// ----------------------------------------------------------------------------
package ddoc_pkg;

    // Calendar constants.
    localparam int EPOCH_YEAR      = 1970;
    localparam int CYCLE_BASE_YEAR = 1969;
    localparam int DAYS_PER_YEAR   = 365;
    localparam int DAYS_PER_CYCLE  = 1461;
    localparam int FEB_LEAP_DAYS   = 29;

    // Reciprocal of the four-year cycle length: q = (d * RECIP) >> RECIP_SHIFT
    // is exact for every 16-bit d.
    localparam logic [15:0] RECIP       = 16'd45934;
    localparam int          RECIP_SHIFT = 26;

    // Index of December in zero-based month numbering.
    localparam logic [3:0] LAST_MONTH_IDX = 4'd11;

    // Month lengths of a common year, January first.
    localparam logic [4:0] MONTH_LEN [12] = '{
        5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
        5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
    };

    // Days of a common year before the first of each month.
    localparam logic [8:0] CUM_DAYS [12] = '{
        9'd0,   9'd31,  9'd59,  9'd90,  9'd120, 9'd151,
        9'd181, 9'd212, 9'd243, 9'd273, 9'd304, 9'd334
    };

    // Controller states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_BASE,
        ST_TOTAL,
        ST_QUOT,
        ST_REM,
        ST_YEAR,
        ST_MONTH,
        ST_DONE
    } ctrl_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_in;
        logic base;
        logic total;
        logic quot;
        logic rem;
        logic year;
        logic month_step;
        logic load_out;
    } ddoc_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic out_range;
        logic month_more;
        logic out_free;
    } ddoc_stat_t;

    // Length of a month given by its zero-based index.
    function automatic logic [4:0] month_length(input logic [3:0] idx, input logic leap);
        logic [4:0] len;
        if (idx == 4'd1) begin
            len = leap ? 5'(FEB_LEAP_DAYS) : MONTH_LEN[1];
        end
        else if (idx > LAST_MONTH_IDX) begin
            len = MONTH_LEN[11];
        end
        else begin
            len = MONTH_LEN[idx];
        end
        return len;
    endfunction

    // Days of the year before the first of a one-based month (1..12).
    function automatic logic [8:0] days_before_month(input logic [3:0] month,
                                                     input logic leap);
        logic [3:0] idx;
        logic [8:0] days;
        idx  = month - 4'd1;
        days = CUM_DAYS[idx];
        if (leap && month >= 4'd3) begin
            days = days + 9'd1;
        end
        return days;
    endfunction

endpackage

// ----- design/ddoc_query_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Query channel
// Carries a starting date and a signed day offset with a valid/ready
// handshake.
// ----------------------------------------------------------------------------
interface ddoc_query_if;

    logic               valid;
    logic               ready;
    logic [4:0]         in_day;
    logic [3:0]         in_month;
    logic [11:0]        in_year;
    logic signed [16:0] day_offset;

    modport source (
        output valid,
        output in_day,
        output in_month,
        output in_year,
        output day_offset,
        input  ready
    );

    modport sink (
        input  valid,
        input  in_day,
        input  in_month,
        input  in_year,
        input  day_offset,
        output ready
    );

endinterface

// ----- design/ddoc_result_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Result channel
// Carries the resulting date, its day serial and the range flag with a
// valid/ready handshake.
// ----------------------------------------------------------------------------
interface ddoc_result_if;

    logic        valid;
    logic        ready;
    logic [4:0]  out_day;
    logic [3:0]  out_month;
    logic [11:0] out_year;
    logic [15:0] day_serial;
    logic        out_of_range;

    modport source (
        output valid,
        output out_day,
        output out_month,
        output out_year,
        output day_serial,
        output out_of_range,
        input  ready
    );

    modport sink (
        input  valid,
        input  out_day,
        input  out_month,
        input  out_year,
        input  day_serial,
        input  out_of_range,
        output ready
    );

endinterface

// ----- design/ddoc_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Date day-offset converter controller
// Sequences one conversion through the datapath: base days, total and range
// check, cycle quotient, remainder, year decode, month walk and result load.
// ----------------------------------------------------------------------------
module ddoc_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 query_valid,
    output logic                 query_ready,
    input  ddoc_pkg::ddoc_stat_t stat,
    output ddoc_pkg::ddoc_cmd_t  cmd
);

    import ddoc_pkg::*;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next-state logic.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (query_valid)
                begin
                    state_next = ST_BASE;
                end
            end
            ST_BASE:  state_next = ST_TOTAL;
            ST_TOTAL: state_next = stat.out_range ? ST_DONE : ST_QUOT;
            ST_QUOT:  state_next = ST_REM;
            ST_REM:   state_next = ST_YEAR;
            ST_YEAR:  state_next = ST_MONTH;
            ST_MONTH:
            begin
                if (!stat.month_more)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (stat.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    // Output logic.
    always_comb
    begin
        cmd         = '0;
        query_ready = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                query_ready = 1'b1;
                cmd.load_in = query_valid;
            end
            ST_BASE:  cmd.base  = 1'b1;
            ST_TOTAL: cmd.total = 1'b1;
            ST_QUOT:  cmd.quot  = 1'b1;
            ST_REM:   cmd.rem   = 1'b1;
            ST_YEAR:  cmd.year  = 1'b1;
            ST_MONTH: cmd.month_step = stat.month_more;
            ST_DONE:  cmd.load_out   = stat.out_free;
            default:  cmd = '0;
        endcase
    end

    // An accepted transfer always starts the base computation next.
    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        query_valid && query_ready |=> state_reg == ST_BASE)
        else $error("accepted transfer did not start a conversion");

    // A result is never loaded over one that is still waiting.
    a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> stat.out_free)
        else $error("result loaded while output register busy");

endmodule

// ----- design/ddoc_dpath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Date day-offset converter datapath
// Converts the date to a day serial, adds the offset, checks the range and
// decodes the sum back into year, month and day under controller commands.
// ----------------------------------------------------------------------------
module ddoc_dpath #(
    parameter int SERIAL_LIMIT = 47482
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  ddoc_pkg::ddoc_cmd_t  cmd,
    output ddoc_pkg::ddoc_stat_t stat,
    input  logic [4:0]           in_day,
    input  logic [3:0]           in_month,
    input  logic [11:0]          in_year,
    input  logic signed [16:0]   day_offset,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [4:0]           out_day,
    output logic [3:0]           out_month,
    output logic [11:0]          out_year,
    output logic [15:0]          day_serial,
    output logic                 out_of_range
);

    import ddoc_pkg::*;

    localparam logic signed [22:0] LIMIT_S = 23'(SERIAL_LIMIT);

    // Captured query.
    logic [4:0]         day_reg;
    logic [3:0]         month_reg;
    logic [11:0]        year_reg;
    logic signed [16:0] offset_reg;

    // Conversion state.
    logic signed [21:0] base_reg;
    logic               oor_reg;
    logic [15:0]        serial_reg;
    logic [15:0]        dcount_reg;
    logic [5:0]         quot_reg;
    logic [10:0]        rem_reg;
    logic [11:0]        ry_reg;
    logic [8:0]         doy_reg;
    logic [3:0]         mon_reg;
    logic               leap_reg;

    // Output register.
    logic               out_valid_reg;
    logic [4:0]         out_day_reg;
    logic [3:0]         out_month_reg;
    logic [11:0]        out_year_reg;
    logic [15:0]        out_serial_reg;
    logic               out_oor_reg;

    // Days of the whole years between 1970 and the start of the input year.
    logic signed [13:0] yrel;
    logic signed [21:0] base_next;
    assign yrel      = $signed({2'b00, year_reg}) - 14'sd1970;
    assign base_next = 22'(yrel) * 22'sd365 + 22'((yrel + 14'sd1) >>> 2);

    // Serial of the starting date plus the offset, and the range check.
    logic [3:0]         month_clamp;
    logic [8:0]         cum_days;
    logic signed [22:0] total;
    logic signed [22:0] dcount_full;
    logic               total_oor;
    always_comb
    begin
        if (month_reg == 4'd0)
        begin
            month_clamp = 4'd1;
        end
        else if (month_reg > 4'd12)
        begin
            month_clamp = 4'd12;
        end
        else
        begin
            month_clamp = month_reg;
        end
        cum_days    = days_before_month(month_clamp, year_reg[1:0] == 2'b00);
        total       = 23'(base_reg) + $signed({14'd0, cum_days})
                    + $signed({18'd0, day_reg}) + 23'(offset_reg);
        total_oor   = (total < 23'sd1) || (total > LIMIT_S);
        dcount_full = total + 23'sd364;
    end

    // Four-year cycle quotient by reciprocal multiplication.
    logic [31:0] quot_prod;
    assign quot_prod = {16'd0, dcount_reg} * {16'd0, RECIP};

    // Remainder within the four-year cycle.
    logic [15:0] rem_full;
    assign rem_full = dcount_reg - 16'({10'd0, quot_reg} * 16'(DAYS_PER_CYCLE));

    // Year within the cycle, capped at the leap year.
    logic [1:0]  ycyc;
    logic [10:0] ycyc_days;
    always_comb
    begin
        if (rem_reg >= 11'd1095)
        begin
            ycyc = 2'd3;
        end
        else if (rem_reg >= 11'd730)
        begin
            ycyc = 2'd2;
        end
        else if (rem_reg >= 11'd365)
        begin
            ycyc = 2'd1;
        end
        else
        begin
            ycyc = 2'd0;
        end
        case (ycyc)
            2'd0:    ycyc_days = 11'd0;
            2'd1:    ycyc_days = 11'd365;
            2'd2:    ycyc_days = 11'd730;
            default: ycyc_days = 11'd1095;
        endcase
    end

    // Month walk: one month length per step.
    logic [4:0] cur_len;
    assign cur_len         = month_length(mon_reg, leap_reg);
    assign stat.month_more = (mon_reg < LAST_MONTH_IDX) && (doy_reg > {4'd0, cur_len});
    assign stat.out_range  = total_oor;
    assign stat.out_free   = !out_valid_reg || out_ready;

    // Working registers.
    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            day_reg    <= in_day;
            month_reg  <= in_month;
            year_reg   <= in_year;
            offset_reg <= day_offset;
        end
        if (cmd.base)
        begin
            base_reg <= base_next;
        end
        if (cmd.total)
        begin
            oor_reg    <= total_oor;
            serial_reg <= total[15:0];
            dcount_reg <= dcount_full[15:0];
        end
        if (cmd.quot)
        begin
            quot_reg <= quot_prod[RECIP_SHIFT +: 6];
        end
        if (cmd.rem)
        begin
            rem_reg <= rem_full[10:0];
        end
        if (cmd.year)
        begin
            ry_reg   <= 12'(CYCLE_BASE_YEAR) + {4'd0, quot_reg, 2'b00} + {10'd0, ycyc};
            doy_reg  <= 9'(rem_reg - ycyc_days) + 9'd1;
            mon_reg  <= 4'd0;
            leap_reg <= (ycyc == 2'd3);
        end
        if (cmd.month_step)
        begin
            doy_reg <= doy_reg - {4'd0, cur_len};
            mon_reg <= mon_reg + 4'd1;
        end
    end

    // Output valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Output payload; an out-of-range result carries zero fields.
    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            out_oor_reg <= oor_reg;
            if (oor_reg)
            begin
                out_day_reg    <= 5'd0;
                out_month_reg  <= 4'd0;
                out_year_reg   <= 12'd0;
                out_serial_reg <= 16'd0;
            end
            else
            begin
                out_day_reg    <= doy_reg[4:0];
                out_month_reg  <= mon_reg + 4'd1;
                out_year_reg   <= ry_reg;
                out_serial_reg <= serial_reg;
            end
        end
    end

    assign out_valid    = out_valid_reg;
    assign out_day      = out_day_reg;
    assign out_month    = out_month_reg;
    assign out_year     = out_year_reg;
    assign day_serial   = out_serial_reg;
    assign out_of_range = out_oor_reg;

    // An out-of-range result shows only zero fields.
    a_oor_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_oor_reg |->
            out_day_reg == 5'd0 && out_month_reg == 4'd0 &&
            out_year_reg == 12'd0 && out_serial_reg == 16'd0)
        else $error("out-of-range result with nonzero fields");

    // An in-range result has a real month and a nonzero day.
    a_date_sane: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_oor_reg |->
            out_month_reg >= 4'd1 && out_month_reg <= 4'd12 &&
            out_day_reg != 5'd0 && out_serial_reg != 16'd0)
        else $error("in-range result with an impossible date");

endmodule

// ----- design/date_day_offset_converter.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Date day-offset converter
// A query runs through base days, total and range check, cycle quotient,
// remainder, year decode and the month walk, which steps one month per cycle;
// an out-of-range result skips from the range check to the result load. A new
// query is accepted only after the last result is loaded into the output register.
// A waiting result does not block the next query: the output register holds it.
// Reset (rst_n, asynchronous, active low) returns the controller to idle and
// empties the output register.
// ----------------------------------------------------------------------------
module date_day_offset_converter #(
    parameter int LAST_YEAR = 2099
) (
    input  logic          clk,
    input  logic          rst_n,
    ddoc_query_if.sink    query,
    ddoc_result_if.source result
);

    import ddoc_pkg::*;

    // Last serial of the supported years.
    localparam int SERIAL_LIMIT = DAYS_PER_YEAR * (LAST_YEAR + 1 - EPOCH_YEAR)
                                + (LAST_YEAR + 1 - CYCLE_BASE_YEAR) / 4;

    ddoc_cmd_t  cmd;
    ddoc_stat_t stat;

    // Sequencing.
    ddoc_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .query_valid (query.valid),
        .query_ready (query.ready),
        .stat        (stat),
        .cmd         (cmd)
    );

    // Arithmetic and result register.
    ddoc_dpath #(
        .SERIAL_LIMIT (SERIAL_LIMIT)
    ) u_dpath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .in_day       (query.in_day),
        .in_month     (query.in_month),
        .in_year      (query.in_year),
        .day_offset   (query.day_offset),
        .out_valid    (result.valid),
        .out_ready    (result.ready),
        .out_day      (result.out_day),
        .out_month    (result.out_month),
        .out_year     (result.out_year),
        .day_serial   (result.day_serial),
        .out_of_range (result.out_of_range)
    );

endmodule
